// ===== design/epc_pkg.sv =====
// shared constants, codes and types of the exponent palette colour mapper
`default_nettype none
package epc_pkg;
  localparam int PalDepth = 16;
  localparam int AddrW    = $clog2(PalDepth);
  localparam int CountW   = $clog2(PalDepth + 1);
  localparam int ValW     = 32;
  localparam int FracW    = 16;
  localparam int FracOneW = FracW + 1;
  localparam int ColorW   = 24;

  typedef enum logic [1:0] {
    CMD_PIXEL      = 2'd0,
    CMD_APPEND_POS = 2'd1,
    CMD_APPEND_NEG = 2'd2,
    CMD_CLEAR      = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    REG_COLOR_MODE     = 3'd0,
    REG_POS_CLAMP_LOW  = 3'd1,
    REG_POS_CLAMP_HIGH = 3'd2,
    REG_NEG_CLAMP_LOW  = 3'd3,
    REG_NEG_CLAMP_HIGH = 3'd4,
    REG_LARGEST_POS    = 3'd5,
    REG_SMALLEST_NEG   = 3'd6
  } reg_e;

  typedef enum logic [1:0] {
    FORCE_NONE = 2'd0,
    FORCE_ZERO = 2'd1,
    FORCE_FULL = 2'd2
  } force_e;

  // per-item control carried down the pipeline
  typedef struct packed {
    logic              pixel;
    logic              wr;
    logic              neg;
    logic              last;
    logic              black;
    logic [AddrW-1:0]  nm1;
    logic [AddrW-1:0]  waddr;
    logic [ColorW-1:0] entry;
  } side_t;
endpackage
`default_nettype wire

// ===== design/exponent_palette_colormap.sv =====
// top level: exponent to rgb colour mapper with two loadable palettes
//
// channel | dir | handshake             | payload
// s_axis  | in  | tvalid/tready         | tdata: exponent, entry_color; tuser: command, not_finite
// m_axis  | out | tvalid/tready         | tdata: red, green, blue
// cfg     | in  | cfg_we_i (no wait)    | cfg_idx_i, cfg_data_i
//
// one item per clock while the output is not stalled; the pipeline depth is
// set mostly by the 16-stage restoring divider that forms the fraction.
// palette writes are done at the same stage as palette reads, so items stay in order.
// reset empties both palettes and loads the register defaults.
// a stalled output holds the whole pipeline; s_axis_tready_o follows the output stage.
`default_nettype none
module exponent_palette_colormap (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [55:0] s_axis_tdata_i,   // exponent[31:0], entry_color[55:32]
  input  wire logic [2:0]  s_axis_tuser_i,   // command[1:0], not_finite[2]
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [23:0]      m_axis_tdata_o,   // red[7:0], green[15:8], blue[23:16]
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_data_i
);
  localparam int AW = epc_pkg::AddrW;
  localparam int CW = epc_pkg::CountW;
  localparam int FW = epc_pkg::FracW;
  localparam int TW = epc_pkg::FracOneW;
  localparam int PW = TW + AW;

  // configuration
  logic                     mode_q;
  logic signed [31:0]       pcl_q, pch_q, ncl_q, nch_q, lpos_q, sneg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
      pcl_q  <= 32'sd0;
      pch_q  <= 32'sh1000_0000;
      ncl_q  <= -32'sh1000_0000;
      nch_q  <= 32'sd0;
      lpos_q <= 32'sh1000_0000;
      sneg_q <= -32'sh1000_0000;
    end else if (cfg_we_i) begin
      case (epc_pkg::reg_e'(cfg_idx_i))
        epc_pkg::REG_COLOR_MODE:     mode_q <= cfg_data_i[0];
        epc_pkg::REG_POS_CLAMP_LOW:  pcl_q  <= cfg_data_i;
        epc_pkg::REG_POS_CLAMP_HIGH: pch_q  <= cfg_data_i;
        epc_pkg::REG_NEG_CLAMP_LOW:  ncl_q  <= cfg_data_i;
        epc_pkg::REG_NEG_CLAMP_HIGH: nch_q  <= cfg_data_i;
        epc_pkg::REG_LARGEST_POS:    lpos_q <= cfg_data_i;
        epc_pkg::REG_SMALLEST_NEG:   sneg_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic en, accept;
  assign en              = !m_axis_tvalid_o || m_axis_tready_i;
  assign s_axis_tready_o = en;
  assign accept          = s_axis_tvalid_i && en;

  // stage 0: decode, counts, clamp
  epc_pkg::cmd_e       cmd;
  logic signed [31:0]  x, clo, chi, dv, xa, xc;
  logic [CW-1:0]       pcnt_q, ncnt_q, n;
  epc_pkg::side_t      side0;
  logic                pfull, nfull;

  assign cmd   = epc_pkg::cmd_e'(s_axis_tuser_i[1:0]);
  assign x     = s_axis_tdata_i[31:0];
  assign pfull = (pcnt_q == CW'(epc_pkg::PalDepth));
  assign nfull = (ncnt_q == CW'(epc_pkg::PalDepth));
  assign n     = x[31] ? ncnt_q : pcnt_q;

  always_comb begin
    logic [CW-1:0] nm;
    nm = n - CW'(1);
    side0.pixel = (cmd == epc_pkg::CMD_PIXEL);
    side0.wr    = ((cmd == epc_pkg::CMD_APPEND_POS) && !pfull) ||
                  ((cmd == epc_pkg::CMD_APPEND_NEG) && !nfull);
    side0.neg   = side0.pixel ? x[31] : (cmd == epc_pkg::CMD_APPEND_NEG);
    side0.last  = !mode_q || s_axis_tuser_i[2];
    side0.black = (n == '0);
    side0.nm1   = nm[AW-1:0];
    side0.waddr = (cmd == epc_pkg::CMD_APPEND_NEG) ? ncnt_q[AW-1:0] : pcnt_q[AW-1:0];
    side0.entry = s_axis_tdata_i[55:32];
    if (x[31]) begin
      clo = ncl_q;
      chi = nch_q;
      dv  = (sneg_q > ncl_q) ? sneg_q : ncl_q;
    end else begin
      clo = pcl_q;
      chi = pch_q;
      dv  = (lpos_q < pch_q) ? lpos_q : pch_q;
    end
    xa = (x < clo) ? clo : x;
    xc = (xa > chi) ? chi : xa;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pcnt_q <= '0;
      ncnt_q <= '0;
    end else if (accept) begin
      case (cmd)
        epc_pkg::CMD_APPEND_POS: if (!pfull) pcnt_q <= pcnt_q + CW'(1);
        epc_pkg::CMD_APPEND_NEG: if (!nfull) ncnt_q <= ncnt_q + CW'(1);
        epc_pkg::CMD_CLEAR: begin
          pcnt_q <= '0;
          ncnt_q <= '0;
        end
        default: ;
      endcase
    end
  end

  logic               v0_q;
  epc_pkg::side_t     sd0_q;
  logic signed [31:0] xc_q, dv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v0_q <= 1'b0;
    else if (en) v0_q <= s_axis_tvalid_i;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sd0_q <= side0;
      xc_q  <= xc;
      dv_q  <= dv;
    end
  end

  // stage 1: magnitudes and saturation cases
  logic               v1_q;
  epc_pkg::side_t     sd1_q;
  epc_pkg::force_e    fc, fc1_q;
  logic [31:0]        ax, ad, ax1_q, ad1_q;

  assign ax = xc_q[31] ? 32'(-xc_q) : xc_q;
  assign ad = dv_q[31] ? 32'(-dv_q) : dv_q;

  always_comb begin
    if (dv_q == '0)                          fc = epc_pkg::FORCE_FULL;
    else if (xc_q == '0 || xc_q[31] != dv_q[31]) fc = epc_pkg::FORCE_ZERO;
    else if (ax >= ad)                       fc = epc_pkg::FORCE_FULL;
    else                                     fc = epc_pkg::FORCE_NONE;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else if (en) v1_q <= v0_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sd1_q <= sd0_q;
      fc1_q <= fc;
      ax1_q <= ax;
      ad1_q <= ad;
    end
  end

  logic               vd;
  epc_pkg::side_t     sdd;
  logic [TW-1:0]      frac;

  epc_divider u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v1_q),
    .side_i  (sd1_q),
    .force_i (fc1_q),
    .num_i   (ax1_q),
    .den_i   (ad1_q),
    .valid_o (vd),
    .side_o  (sdd),
    .frac_o  (frac)
  );

  // scale by palette length minus one, pick neighbours
  logic [PW-1:0]  pos;
  logic [AW-1:0]  lo, hi;
  logic [FW-1:0]  f;
  logic           vm_q;
  epc_pkg::side_t sdm_q;
  logic [AW-1:0]  lo_q, hi_q;
  logic [FW-1:0]  f_q;

  assign pos = PW'(frac) * PW'(sdd.nm1);

  always_comb begin
    if (sdd.last) begin
      lo = sdd.nm1;
      hi = sdd.nm1;
      f  = '0;
    end else begin
      lo = pos[FW +: AW];
      f  = pos[FW-1:0];
      hi = (f != '0) ? lo + AW'(1) : lo;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vm_q <= 1'b0;
    else if (en) vm_q <= vd;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sdm_q <= sdd;
      lo_q  <= lo;
      hi_q  <= hi;
      f_q   <= f;
    end
  end

  // palette access: appends write here, pixels read here
  logic [23:0] pa, pb, na, nb;

  epc_palette_mem u_pos_pal (
    .clk_i     (clk_i),
    .en_i      (en),
    .we_i      (vm_q && sdm_q.wr && !sdm_q.neg),
    .waddr_i   (sdm_q.waddr),
    .wdata_i   (sdm_q.entry),
    .raddr_a_i (lo_q),
    .raddr_b_i (hi_q),
    .rdata_a_o (pa),
    .rdata_b_o (pb)
  );

  epc_palette_mem u_neg_pal (
    .clk_i     (clk_i),
    .en_i      (en),
    .we_i      (vm_q && sdm_q.wr && sdm_q.neg),
    .waddr_i   (sdm_q.waddr),
    .wdata_i   (sdm_q.entry),
    .raddr_a_i (lo_q),
    .raddr_b_i (hi_q),
    .rdata_a_o (na),
    .rdata_b_o (nb)
  );

  logic          vr_q, pix_r_q, neg_r_q, blk_r_q;
  logic [FW-1:0] f_r_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vr_q <= 1'b0;
    else if (en) vr_q <= vm_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pix_r_q <= sdm_q.pixel;
      neg_r_q <= sdm_q.neg;
      blk_r_q <= sdm_q.black;
      f_r_q   <= f_q;
    end
  end

  // blend: a + ((b - a) * f + half) >> 16, per channel
  logic [23:0] ca, cb, blended;

  assign ca = neg_r_q ? na : pa;
  assign cb = neg_r_q ? nb : pb;

  always_comb begin
    logic signed [8:0]  dch;
    logic signed [25:0] prod;
    logic signed [25:0] acc;
    for (int c = 0; c < 3; c++) begin
      dch  = $signed({1'b0, cb[8*c +: 8]}) - $signed({1'b0, ca[8*c +: 8]});
      prod = 26'(dch) * 26'($signed({1'b0, f_r_q}));
      acc  = $signed({2'b00, ca[8*c +: 8], 16'h0000}) + prod + 26'sh8000;
      blended[8*c +: 8] = acc[23:16];
    end
  end

  logic        ov_q;
  logic [23:0] od_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ov_q <= 1'b0;
    else if (en) ov_q <= vr_q && pix_r_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      od_q <= blk_r_q ? 24'h0 : {blended[7:0], blended[15:8], blended[23:16]};
    end
  end

  assign m_axis_tvalid_o = ov_q;
  assign m_axis_tdata_o  = od_q;
endmodule
`default_nettype wire

// ===== design/epc_divider.sv =====
// pipelined restoring divider, one quotient bit per stage, fraction in q1.16
`default_nettype none
module epc_divider (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            en_i,
  input  wire logic                            valid_i,
  input  wire epc_pkg::side_t                  side_i,
  input  wire epc_pkg::force_e                 force_i,
  input  wire logic [epc_pkg::ValW-1:0]        num_i,
  input  wire logic [epc_pkg::ValW-1:0]        den_i,
  output logic                                 valid_o,
  output epc_pkg::side_t                       side_o,
  output logic [epc_pkg::FracOneW-1:0]         frac_o
);
  localparam int N = epc_pkg::FracW;
  localparam int W = epc_pkg::ValW;

  logic                  v_q   [N];
  epc_pkg::side_t        sd_q  [N];
  epc_pkg::force_e       fc_q  [N];
  logic [W-1:0]          r_q   [N];
  logic [W-1:0]          d_q   [N];
  logic [N-1:0]          qt_q  [N];
  logic [W-1:0]          r_d   [N];
  logic [N-1:0]          qt_d  [N];

  always_comb begin
    logic [W:0]   r2;
    logic [W-1:0] rin;
    logic [W-1:0] din;
    logic [N-1:0] qin;
    logic         ge;
    for (int k = 0; k < N; k++) begin
      rin = (k == 0) ? num_i : r_q[(k == 0) ? 0 : k-1];
      din = (k == 0) ? den_i : d_q[(k == 0) ? 0 : k-1];
      qin = (k == 0) ? '0 : qt_q[(k == 0) ? 0 : k-1];
      r2  = {rin, 1'b0};
      ge  = (r2 >= {1'b0, din});
      r_d[k]  = ge ? W'(r2 - {1'b0, din}) : W'(r2);
      qt_d[k] = {qin[N-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < N; k++) v_q[k] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
      for (int k = 1; k < N; k++) v_q[k] <= v_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sd_q[0] <= side_i;
      fc_q[0] <= force_i;
      d_q[0]  <= den_i;
      for (int k = 1; k < N; k++) begin
        sd_q[k] <= sd_q[k-1];
        fc_q[k] <= fc_q[k-1];
        d_q[k]  <= d_q[k-1];
      end
      for (int k = 0; k < N; k++) begin
        r_q[k]  <= r_d[k];
        qt_q[k] <= qt_d[k];
      end
    end
  end

  assign valid_o = v_q[N-1];
  assign side_o  = sd_q[N-1];

  always_comb begin
    case (fc_q[N-1])
      epc_pkg::FORCE_ZERO: frac_o = '0;
      epc_pkg::FORCE_FULL: frac_o = {1'b1, {N{1'b0}}};
      default:             frac_o = {1'b0, qt_q[N-1]};
    endcase
  end
endmodule
`default_nettype wire

// ===== design/epc_palette_mem.sv =====
// one palette: single write port, two registered read ports
`default_nettype none
module epc_palette_mem (
  input  wire logic                             clk_i,
  input  wire logic                             en_i,
  input  wire logic                             we_i,
  input  wire logic [epc_pkg::AddrW-1:0]        waddr_i,
  input  wire logic [epc_pkg::ColorW-1:0]       wdata_i,
  input  wire logic [epc_pkg::AddrW-1:0]        raddr_a_i,
  input  wire logic [epc_pkg::AddrW-1:0]        raddr_b_i,
  output logic [epc_pkg::ColorW-1:0]            rdata_a_o,
  output logic [epc_pkg::ColorW-1:0]            rdata_b_o
);
  logic [epc_pkg::ColorW-1:0] mem [epc_pkg::PalDepth];

  always_ff @(posedge clk_i) begin
    if (en_i && we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rdata_a_o <= mem[raddr_a_i];
      rdata_b_o <= mem[raddr_b_i];
    end
  end
endmodule
`default_nettype wire

// ===== design/epc_checker.sv =====
// port-level checks of the colour mapper, bound to the top level
`default_nettype none
module epc_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tready_o,
  input wire logic        m_axis_tvalid_o,
  input wire logic        m_axis_tready_i,
  input wire logic [23:0] m_axis_tdata_o
);
  // input side only stalls behind a held result
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o) else $error("input stalled while output empty");

  a_ready_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> (m_axis_tvalid_o && !m_axis_tready_i))
    else $error("input stalled without output back-pressure");

  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> m_axis_tvalid_o)
    else $error("result dropped under stall");

  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> $stable(m_axis_tdata_o))
    else $error("result changed under stall");
endmodule

bind exponent_palette_colormap epc_checker u_epc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);
`default_nettype wire
